### rtl/core/line_scan_smooth_second_difference_macros.svh
// Assertion macros used by the checker file of the line-scan smoothing block.
`ifndef LINE_SCAN_SMOOTH_SECOND_DIFFERENCE_MACROS_SVH
`define LINE_SCAN_SMOOTH_SECOND_DIFFERENCE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define LSSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define LSSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lssd_pkg.sv
// Shared types, constants and arithmetic helpers for the line-scan smoothing block.
package lssd_pkg;

    localparam int PIX_W     = 12;
    localparam int CURV_W    = 14;
    localparam int SUM_W     = 14;
    localparam int WIN_DEPTH = 3;
    localparam int MAX_LINE_PIXELS_DEF = 128;

    // x / 3 == (x * 43691) >> 17 for every x below 2^16
    localparam logic [16:0] DIV3_RECIP = 17'd43691;
    localparam int          DIV3_SHIFT = 17;

    typedef struct packed {
        logic clear;
        logic shift_raw;
        logic shift_smooth;
    } t_cell_ctrl;

    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
        logic [SUM_W+16:0] prod;
        prod = s * DIV3_RECIP;
        return prod[DIV3_SHIFT +: PIX_W];
    endfunction

    // a - 2b + c, wrapped to the result width
    function automatic logic [CURV_W-1:0] second_diff(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] c);
        logic signed [PIX_W+2:0] v;
        v = $signed({3'b000, a}) - $signed({2'b00, b, 1'b0}) + $signed({3'b000, c});
        return v[CURV_W-1:0];
    endfunction

    // a - b, wrapped to the result width
    function automatic logic [CURV_W-1:0] first_diff(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic signed [PIX_W+2:0] v;
        v = $signed({3'b000, a}) - $signed({3'b000, b});
        return v[CURV_W-1:0];
    endfunction

endpackage

### rtl/core/lssd_cell.sv
// One tap of the window chain: holds a raw pixel and a smoothed value.
module lssd_cell
    import lssd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [PIX_W-1:0] i_raw,
    input  logic [PIX_W-1:0] i_smooth,
    output logic [PIX_W-1:0] o_raw,
    output logic [PIX_W-1:0] o_smooth
);

    logic [PIX_W-1:0] r_raw, n_raw;
    logic [PIX_W-1:0] r_smooth, n_smooth;

    always_comb begin
        n_raw    = r_raw;
        n_smooth = r_smooth;
        if (i_ctrl.clear) begin
            n_raw    = '0;
            n_smooth = '0;
        end else begin
            if (i_ctrl.shift_raw) begin
                n_raw = i_raw;
            end
            if (i_ctrl.shift_smooth) begin
                n_smooth = i_smooth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '0;
            r_smooth <= '0;
        end else begin
            r_raw    <= n_raw;
            r_smooth <= n_smooth;
        end
    end

    assign o_raw    = r_raw;
    assign o_smooth = r_smooth;

endmodule

### rtl/core/line_scan_smooth_second_difference.sv
// Top level: 3-tap box smoothing and second forward difference of a line scan.
// One pixel is taken per clock while o_ready is high; each accepted pixel after the third of a
// line, save the one that ends it, puts one curvature result in the output register, seen on the
// following cycle. A pixel carrying i_line_end (or the pixel at index MAX_LINE_PIXELS-1) starts a
// flush of min(L,4) results for a line of L pixels, one per cycle while the output side does not
// stall, with o_ready low meanwhile. The final result of a line is zero and carries o_last_of_line.
// The window is a chain of three cells; raw values shift on every accepted pixel, smoothed values
// on every one but the first of a line; the divide by three is a reciprocal multiply in that path.
module line_scan_smooth_second_difference
    import lssd_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PIX_W-1:0]    i_pixel,
    input  logic                i_line_end,
    input  logic                i_valid,
    output logic                o_ready,
    output logic [CURV_W-1:0]   o_curvature,
    output logic                o_last_of_line,
    output logic                o_valid,
    input  logic                i_ready
);

    localparam int CNT_W = $clog2(MAX_LINE_PIXELS);
    localparam logic [1:0] POS_TAIL_DIFF = 2'd2;
    localparam logic [1:0] POS_END       = 2'd3;

    logic [PIX_W-1:0] w_raw    [WIN_DEPTH];
    logic [PIX_W-1:0] w_smooth [WIN_DEPTH];
    t_cell_ctrl       cell_ctrl;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_flush, n_flush;
    logic [1:0]        r_pos, n_pos;
    logic [PIX_W-1:0]  r_tail, n_tail;
    logic              r_out_valid, n_out_valid;
    logic [CURV_W-1:0] r_out_curv, n_out_curv;
    logic              r_out_last, n_out_last;

    logic              slot_free;
    logic              in_fire;
    logic              is_last;
    logic [SUM_W-1:0]  box_sum;
    logic [PIX_W-1:0]  new_smooth;
    logic              flush_step;
    logic [CURV_W-1:0] flush_val;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = !r_flush && slot_free;
    assign in_fire   = i_valid && o_ready;
    assign is_last   = i_line_end || (r_count == CNT_W'(MAX_LINE_PIXELS - 1));

    // centred average of the pixel before last, using the window after this shift
    assign box_sum    = SUM_W'(w_raw[1]) + SUM_W'(w_raw[2]) + SUM_W'(i_pixel);
    assign new_smooth = (r_count == CNT_W'(1)) ? w_raw[2] : div3(box_sum);

    assign flush_step = r_flush && slot_free;

    always_comb begin
        unique case (r_pos)
            POS_END:       flush_val = '0;
            POS_TAIL_DIFF: flush_val = first_diff(w_smooth[2], r_tail);
            2'd1:          flush_val = second_diff(w_smooth[1], w_smooth[2], r_tail);
            default:       flush_val = second_diff(w_smooth[0], w_smooth[1], w_smooth[2]);
        endcase
    end

    assign cell_ctrl.clear        = flush_step && (r_pos == POS_END);
    assign cell_ctrl.shift_raw    = in_fire;
    assign cell_ctrl.shift_smooth = in_fire && (r_count != '0);

    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        logic [PIX_W-1:0] raw_in, smooth_in;
        if (k == WIN_DEPTH - 1) begin : g_head
            assign raw_in    = i_pixel;
            assign smooth_in = new_smooth;
        end else begin : g_link
            assign raw_in    = w_raw[k+1];
            assign smooth_in = w_smooth[k+1];
        end
        lssd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (cell_ctrl),
            .i_raw    (raw_in),
            .i_smooth (smooth_in),
            .o_raw    (w_raw[k]),
            .o_smooth (w_smooth[k])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_flush     = r_flush;
        n_pos       = r_pos;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !i_ready;
        n_out_curv  = r_out_curv;
        n_out_last  = r_out_last;
        if (in_fire) begin
            if (is_last) begin
                n_count = '0;
                n_flush = 1'b1;
                n_tail  = i_pixel;
                n_pos   = (r_count >= CNT_W'(3)) ? 2'd0 : (POS_END - r_count[1:0]);
            end else begin
                n_count = r_count + CNT_W'(1);
                if (r_count >= CNT_W'(3)) begin
                    n_out_valid = 1'b1;
                    n_out_curv  = second_diff(w_smooth[1], w_smooth[2], new_smooth);
                    n_out_last  = 1'b0;
                end
            end
        end else if (flush_step) begin
            n_out_valid = 1'b1;
            n_out_curv  = flush_val;
            n_out_last  = (r_pos == POS_END);
            if (r_pos == POS_END) begin
                n_flush = 1'b0;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flush     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_flush     <= n_flush;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail     <= n_tail;
        r_out_curv <= n_out_curv;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_curvature    = r_out_curv;
    assign o_last_of_line = r_out_last;

endmodule

### rtl/core/lssd_checker.sv
// Port-level checks for the line-scan smoothing block, bound to its top level.
`include "line_scan_smooth_second_difference_macros.svh"

module lssd_checker
    import lssd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic [PIX_W-1:0]  i_pixel,
    input logic              i_line_end,
    input logic              i_valid,
    input logic              o_ready,
    input logic [CURV_W-1:0] o_curvature,
    input logic              o_last_of_line,
    input logic              o_valid,
    input logic              i_ready
);

    logic in_txn;
    assign in_txn = i_valid && o_ready && (i_pixel == i_pixel);

    // a stalled result holds
    `LSSD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_curvature) && $stable(o_last_of_line), "result changed while stalled")

    // a line end always starts a flush, so input is refused next cycle
    `LSSD_ASSERT_NEXT(a_flush_blocks, in_txn && i_line_end, !o_ready, "input taken during flush")

    // the closing result of a line is always zero
    `LSSD_ASSERT_NOW(a_last_zero, o_valid && o_last_of_line, o_curvature == '0, "last result not zero")

    // second difference of 12-bit values stays inside +/-8190
    `LSSD_ASSERT_NOW(a_curv_range, o_valid, ($signed(o_curvature) >= -14'sd8190) && ($signed(o_curvature) <= 14'sd8190), "curvature out of range")

endmodule

bind line_scan_smooth_second_difference lssd_checker u_lssd_checker (.*);
